[hdl/gradient_magnitude_stream_unit_assert.svh]
// Assertion macros for the gradient magnitude stream unit.
`ifndef GRADIENT_MAGNITUDE_STREAM_UNIT_ASSERT_SVH
`define GRADIENT_MAGNITUDE_STREAM_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define GMS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gms: same-cycle check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define GMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gms: next-cycle check failed");
`else
`define GMS_ASSERT_NOW(label, ante, cons)
`define GMS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hdl/gms_pkg.sv]
// Shared types and constants of the gradient magnitude stream unit.
package gms_pkg;

  localparam int PIX_W      = 8;
  localparam int LW_W       = 11;
  localparam int ROWS_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int SUM_W      = 15;
  localparam int BIT_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'b1;

  localparam logic [LW_W-1:0]   LINE_WIDTH_RST = 11'd1024;
  localparam logic [ROWS_W-1:0] FRAME_ROWS_RST = 16'd1024;

  localparam logic [BIT_IDX_W-1:0] ROOT_MSB = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 accept;
    logic                 calc_dy;
    logic                 calc_sq;
    logic                 root_step;
    logic [BIT_IDX_W-1:0] root_bit;
    logic                 round;
    logic                 load_out;
  } gms_cmd_t;

endpackage

[hdl/gms_ctrl.sv]
// Controller state machine: sequences one pixel through the datapath.
module gms_ctrl
  import gms_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output gms_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIFF  = 3'd1;
  localparam logic [2:0] S_SQ    = 3'd2;
  localparam logic [2:0] S_ROOT  = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [BIT_IDX_W-1:0] bit_r, bit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    bit_nxt      = bit_r;
    cmd          = '0;
    cmd.root_bit = bit_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.calc_dy = 1'b1;
        state_nxt   = S_SQ;
      end
      S_SQ: begin
        cmd.calc_sq = 1'b1;
        bit_nxt     = ROOT_MSB;
        state_nxt   = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (bit_r == '0) begin
          state_nxt = S_ROUND;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/gms_datapath.sv]
// Datapath: line store, counters, gradients, squares, iterative rounded root.
module gms_datapath
  import gms_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gms_cmd_t              cmd,
  input  logic [PIX_W-1:0]      pixel,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [PIX_W-1:0]      grad_x,
  output logic [PIX_W-1:0]      grad_y,
  output logic [PIX_W-1:0]      magnitude,
  output logic                  frame_end
);

  localparam int CNT_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W = (CNT_W + 1 > LW_W) ? CNT_W + 1 : LW_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_WIDTH);

  logic [PIX_W-1:0]  line_mem [MAX_WIDTH];

  logic [LW_W-1:0]   line_width_r;
  logic [ROWS_W-1:0] frame_rows_r;
  logic [CNT_W-1:0]  col_r;
  logic [ROWS_W-1:0] row_r;
  logic [PIX_W-1:0]  left_r;

  logic [PIX_W-1:0]  pix_r, above_r, dx_r, dy_r;
  logic              row_zero_r, flast_r;
  logic [SUM_W-1:0]  sum_r;
  logic [PIX_W-1:0]  root_r, mag_r;
  logic [PIX_W-1:0]  gx_out_r, gy_out_r, mag_out_r;
  logic              fe_out_r;

  logic [CMP_W-1:0]  width_eff, col_inc;
  logic [ROWS_W:0]   rows_eff, row_inc;
  logic              row_last, frame_last;
  logic [PIX_W-1:0]  dx_nxt;
  logic [PIX_W:0]    diff, diff_adj;
  logic [PIX_W-1:0]  abs_x, abs_y;
  logic [2*PIX_W-1:0] sq_x, sq_y, sq_sum;
  logic [PIX_W-1:0]  cand;
  logic [2*PIX_W-1:0] cand_sq, root_prod;

  // Clamp the configured sizes to what the store supports.
  always_comb begin
    width_eff = CMP_W'(line_width_r);
    if (line_width_r == '0) begin
      width_eff = CMP_W'(1);
    end else if (CMP_W'(line_width_r) > MAX_CMP) begin
      width_eff = MAX_CMP;
    end
    rows_eff = (frame_rows_r == '0) ? (ROWS_W + 1)'(1) : {1'b0, frame_rows_r};
  end

  assign col_inc    = CMP_W'(col_r) + CMP_W'(1);
  assign row_inc    = {1'b0, row_r} + (ROWS_W + 1)'(1);
  assign row_last   = (col_inc >= width_eff);
  assign frame_last = row_last && (row_inc >= rows_eff);
  assign dx_nxt     = (col_r == '0) ? '0 : pixel - left_r;

  // Half of the vertical difference, truncated toward zero.
  assign diff     = {1'b0, pix_r} - {1'b0, above_r};
  assign diff_adj = diff + (PIX_W + 1)'(diff[PIX_W]);

  assign abs_x  = dx_r[PIX_W-1] ? (~dx_r + 1'b1) : dx_r;
  assign abs_y  = dy_r[PIX_W-1] ? (~dy_r + 1'b1) : dy_r;
  assign sq_x   = abs_x * abs_x;
  assign sq_y   = abs_y * abs_y;
  assign sq_sum = sq_x + sq_y;

  assign cand      = root_r | (PIX_W'(1) << cmd.root_bit);
  assign cand_sq   = cand * cand;
  assign root_prod = root_r * root_r + (2*PIX_W)'(root_r);

  // Line store: read the pixel above, then overwrite it with the current one.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      line_mem[col_r] <= pixel;
      above_r         <= line_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RST;
      frame_rows_r <= FRAME_ROWS_RST;
      col_r        <= '0;
      row_r        <= '0;
      left_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_LINE_WIDTH: line_width_r <= cfg_wdata[LW_W-1:0];
          REG_FRAME_ROWS: frame_rows_r <= cfg_wdata[ROWS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        left_r <= pixel;
        if (row_last) begin
          col_r <= '0;
          row_r <= frame_last ? '0 : row_inc[ROWS_W-1:0];
        end else begin
          col_r <= col_inc[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r      <= pixel;
      dx_r       <= dx_nxt;
      row_zero_r <= (row_r == '0);
      flast_r    <= frame_last;
    end
    if (cmd.calc_dy) begin
      dy_r <= row_zero_r ? '0 : diff_adj[PIX_W:1];
    end
    if (cmd.calc_sq) begin
      sum_r  <= sq_sum[SUM_W-1:0];
      root_r <= '0;
    end
    if (cmd.root_step && (cand_sq <= (2*PIX_W)'(sum_r))) begin
      root_r <= cand;
    end
    if (cmd.round) begin
      mag_r <= root_r + PIX_W'((2*PIX_W)'(sum_r) > root_prod);
    end
    if (cmd.load_out) begin
      gx_out_r  <= dx_r;
      gy_out_r  <= dy_r;
      mag_out_r <= mag_r;
      fe_out_r  <= flast_r;
    end
  end

  assign grad_x    = gx_out_r;
  assign grad_y    = gy_out_r;
  assign magnitude = mag_out_r;
  assign frame_end = fe_out_r;

endmodule

[hdl/gradient_magnitude_stream_unit.sv]
// Top level of the gradient magnitude stream unit.
//
//  channel | direction | beat content
//  --------+-----------+----------------------------------------------------
//  in_     | input     | one grayscale pixel, raster order
//  out_    | output    | grad_x, grad_y, magnitude; tlast on last frame pixel
//  cfg_    | input     | register write: 0 = line_width, 1 = frame_rows
//
//  A pixel goes from the accepting edge to its result register through vertical
//  difference, sum of squares, eight root bits (one per cycle), rounding, output load.
//  A new pixel is taken only once the last one has reached the output stage; the next
//  pixel is taken while the previous result waits in the output register.
//  Reset (rst_n low, synchronous) clears counters, left pixel and output valid and sets
//  both registers to 1024. A stalled output holds its beat; cfg writes are always taken.
module gradient_magnitude_stream_unit
  import gms_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] pixel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // [7:0] grad_x, [15:8] grad_y, [23:16] magnitude
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "gradient_magnitude_stream_unit_assert.svh"

  gms_cmd_t         cmd;
  logic [PIX_W-1:0] grad_x, grad_y, magnitude;
  logic             frame_end;

  // Configuration writes land in the datapath registers at once.
  assign cfg_ready = 1'b1;

  gms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  gms_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .pixel     (in_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .grad_x    (grad_x),
    .grad_y    (grad_y),
    .magnitude (magnitude),
    .frame_end (frame_end)
  );

  assign out_tdata = {magnitude, grad_y, grad_x};
  assign out_tlast = frame_end;

  // One pixel at a time: an accepted beat closes the input until its result.
  `GMS_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)
  // The rounded root of the largest sum of squares stays at or below 181.
  `GMS_ASSERT_NOW(a_mag_bound, out_tvalid, out_tdata[23:16] <= 8'd181)
  // No gradient in either direction means no magnitude.
  `GMS_ASSERT_NOW(a_zero_grad, out_tvalid && out_tdata[15:0] == 16'd0,
                  out_tdata[23:16] == 8'd0)

endmodule

[tb/tb.sv]
// Self-checking testbench for the gradient magnitude stream unit.
`timescale 1ns / 100ps

module tb
  import gms_pkg::*;
();

  localparam int LINE_DEPTH  = 1024;     // line store depth of the instance
  localparam int ITEM_TARGET = 1700;     // pixels to send before stopping
  localparam int SETTLE      = 16;       // extra wait after the last expected result
  localparam int HOLD_CYCLES = 400;      // long receiver hold-off
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  // One result beat, unpacked from out_tdata / out_tlast.
  typedef struct packed {
    logic [7:0] grad_x;
    logic [7:0] grad_y;
    logic [7:0] magnitude;
    logic       frame_end;
  } grad_beat_t;

  // One row of the directed table: a register write or a pixel, with an
  // optional hand-written result.
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [PIX_W-1:0]      pix;
    logic                  typed;
    grad_beat_t            want;
  } stim_row_t;

  localparam grad_beat_t NO_BEAT = '0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: line store, left neighbour, position and registers.
  logic [7:0]        line_mem [LINE_DEPTH];
  bit                line_written [LINE_DEPTH];
  logic [7:0]        left_q = '0;
  int                col_pos = 0;
  int                row_pos = 0;
  logic [LW_W-1:0]   line_width_q = LINE_WIDTH_RST;
  logic [ROWS_W-1:0] frame_rows_q = FRAME_ROWS_RST;

  grad_beat_t pending_grads [$];
  int         pixels_sent  = 0;
  int         results_seen = 0;
  int         fail_count   = 0;
  logic       hold_off     = 1'b0;

  // Directed rows: reset state, out-of-range registers, wrap of grad_x, both
  // signs of grad_y with truncation, the largest magnitude, a width shrunk
  // mid-row, a row count shrunk mid-frame and the register maximums.
  stim_row_t directed_rows [28] = '{
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd0,   1'b1, '{8'h00, 8'h00, 8'd0,   1'b0}},
    '{ROW_CFG, REG_LINE_WIDTH, 16'd0,     8'd0,   1'b0, NO_BEAT},
    '{ROW_CFG, REG_FRAME_ROWS, 16'd0,     8'd0,   1'b0, NO_BEAT},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd255, 1'b1, '{8'hFF, 8'h00, 8'd1,   1'b1}},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd200, 1'b1, '{8'h00, 8'h00, 8'd0,   1'b1}},
    '{ROW_CFG, REG_LINE_WIDTH, 16'd2,     8'd0,   1'b0, NO_BEAT},
    '{ROW_CFG, REG_FRAME_ROWS, 16'd3,     8'd0,   1'b0, NO_BEAT},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd0,   1'b1, '{8'h00, 8'h00, 8'd0,   1'b0}},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd128, 1'b1, '{8'h80, 8'h00, 8'd128, 1'b0}},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd255, 1'b1, '{8'h00, 8'h7F, 8'd127, 1'b0}},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd1,   1'b0, NO_BEAT},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd0,   1'b1, '{8'h00, 8'h81, 8'd127, 1'b0}},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd127, 1'b0, NO_BEAT},
    '{ROW_CFG, REG_FRAME_ROWS, 16'd2,     8'd0,   1'b0, NO_BEAT},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd5,   1'b0, NO_BEAT},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd0,   1'b0, NO_BEAT},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd127, 1'b0, NO_BEAT},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd255, 1'b1, '{8'h80, 8'h7F, 8'd180, 1'b1}},
    '{ROW_CFG, REG_FRAME_ROWS, 16'd4,     8'd0,   1'b0, NO_BEAT},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd9,   1'b0, NO_BEAT},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd250, 1'b0, NO_BEAT},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd3,   1'b0, NO_BEAT},
    '{ROW_CFG, REG_FRAME_ROWS, 16'd1,     8'd0,   1'b0, NO_BEAT},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd77,  1'b0, NO_BEAT},
    '{ROW_CFG, REG_LINE_WIDTH, 16'hFFFF,  8'd0,   1'b0, NO_BEAT},
    '{ROW_CFG, REG_FRAME_ROWS, 16'hFFFF,  8'd0,   1'b0, NO_BEAT},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd77,  1'b1, '{8'h00, 8'h00, 8'd0,   1'b0}},
    '{ROW_PIX, REG_LINE_WIDTH, 16'd0,     8'd0,   1'b0, NO_BEAT}
  };

  gradient_magnitude_stream_unit #(
    .MAX_WIDTH(LINE_DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [7:0] pixel
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // [7:0] grad_x, [15:8] grad_y, [23:16] magnitude
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp the width register into 1..LINE_DEPTH.
  function automatic int active_width(logic [LW_W-1:0] v);
    if (v == 0) return 1;
    if (v > LINE_DEPTH) return LINE_DEPTH;
    return int'(v);
  endfunction

  function automatic int active_rows();
    return (frame_rows_q == 0) ? 1 : int'(frame_rows_q);
  endfunction

  // Count line store entries written so far, from column 0 up without a hole.
  function automatic int filled_prefix();
    int n;
    n = 0;
    while (n < LINE_DEPTH && line_written[n]) n++;
    return n;
  endfunction

  // Pixels left up to and including the next frame end.
  function automatic int pixels_to_frame_end();
    int w, cols_left, rows_left;
    w = active_width(line_width_q);
    cols_left = (col_pos + 1 >= w) ? 1 : w - col_pos;
    rows_left = (row_pos + 1 >= active_rows()) ? 0 : active_rows() - row_pos - 1;
    return cols_left + rows_left * w;
  endfunction

  // Work out the gradients of one pixel and advance the raster position.
  function automatic grad_beat_t predict_gradient(logic [7:0] pix);
    grad_beat_t res;
    int         w, gx, gy, sumsq, root;
    logic [7:0] gx_wrap;
    logic       row_end;
    w = active_width(line_width_q);
    gx_wrap = (col_pos != 0) ? pix - left_q : 8'd0;
    gx = int'($signed(gx_wrap));
    gy = 0;
    if (row_pos != 0) gy = (int'(pix) - int'(line_mem[col_pos])) / 2;
    sumsq = gx * gx + gy * gy;
    // Nearest integer root: count r >= 1 with r*(r-1) below the sum.
    root = 0;
    while (root < 255 && (root + 1) * root < sumsq) root++;
    row_end = (col_pos + 1 >= w);
    res.grad_x    = gx_wrap;
    res.grad_y    = gy[7:0];
    res.magnitude = root[7:0];
    res.frame_end = row_end && (row_pos + 1 >= active_rows());
    line_mem[col_pos]     = pix;
    line_written[col_pos] = 1'b1;
    left_q = pix;
    if (row_end) begin
      col_pos = 0;
      row_pos = res.frame_end ? 0 : (row_pos + 1) & 16'hFFFF;
    end else begin
      col_pos++;
    end
    return res;
  endfunction

  // Idle shares in percent: receiver-heavy, then sender-heavy, then none.
  function automatic int send_idle_pct();
    if (pixels_sent < ITEM_TARGET / 3) return 32;
    if (pixels_sent < 2 * ITEM_TARGET / 3) return 74;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (pixels_sent < ITEM_TARGET / 3) return 74;
    if (pixels_sent < 2 * ITEM_TARGET / 3) return 32;
    return 0;
  endfunction

  // Mostly random pixels, now and then a value at or next to an extreme.
  function automatic logic [7:0] rand_pixel();
    if ($urandom_range(7) != 0) return 8'($urandom_range(255));
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd127;
      default: return 8'd128;
    endcase
  endfunction

  // Offer one pixel beat, idling first at random; leave tvalid high on return
  // so back-to-back beats need no second assignment in the same step.
  task automatic push_pixel(input logic [7:0] pix, input logic typed,
                            input grad_beat_t want);
    grad_beat_t predicted;
    if (cfg_valid) cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    predicted = predict_gradient(pix);
    pending_grads.push_back(typed ? want : predicted);
    pixels_sent++;
  endtask

  // Write one register; cfg_valid stays high until the next pixel lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (sel == REG_LINE_WIDTH) line_width_q = value[LW_W-1:0];
    else frame_rows_q = value[ROWS_W-1:0];
  endtask

  // Stop offering pixels and let every outstanding result come out.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic check_beat();
    grad_beat_t got, want;
    got.grad_x    = out_tdata[7:0];
    got.grad_y    = out_tdata[15:8];
    got.magnitude = out_tdata[23:16];
    got.frame_end = out_tlast;
    results_seen++;
    if (pending_grads.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: beat with nothing outstanding: gx %h gy %h mag %0d last %b",
                 $realtime, got.grad_x, got.grad_y, got.magnitude, got.frame_end);
    end else begin
      want = pending_grads.pop_front();
      if (got.grad_x !== want.grad_x || got.grad_y !== want.grad_y ||
          got.magnitude !== want.magnitude || got.frame_end !== want.frame_end) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: beat %0d: want %h %h %0d %b, got %h %h %0d %b",
                   $realtime, results_seen, want.grad_x, want.grad_y, want.magnitude,
                   want.frame_end, got.grad_x, got.grad_y, got.magnitude, got.frame_end);
      end
    end
  endtask

  // Result side: check each accepted beat, then draw the next tready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_beat();
      out_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // Back-pressure: once traffic is flowing, refuse results for a long stretch
  // so the block fills up and drops in_tready while pixels are still offered.
  initial begin
    wait (results_seen >= 150);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("gradient_magnitude_stream_unit regression: fail");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] cfg_word;
    int                    burst;
    bit                    prev_cfg;

    foreach (line_written[i]) line_written[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table; drain before the first write of a group.
    prev_cfg = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (!prev_cfg) wait_idle();
        write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
        prev_cfg = 1'b1;
      end else begin
        push_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
        prev_cfg = 1'b0;
      end
    end

    // One wide two-row frame so the upper line store addresses see traffic.
    wait_idle();
    write_reg(REG_LINE_WIDTH, 16'd560);
    write_reg(REG_FRAME_ROWS, 16'd2);
    burst = pixels_to_frame_end();
    repeat (burst) push_pixel(rand_pixel(), 1'b0, NO_BEAT);

    // Random phases: new settings at idle, then mostly whole frames.
    while (pixels_sent < ITEM_TARGET) begin
      wait_idle();
      if ($urandom_range(9) >= 3) begin
        case ($urandom_range(9))
          0:       cfg_word = 16'd0;
          1:       cfg_word = 16'd1;
          2:       cfg_word = 16'd1024;
          3:       cfg_word = 16'hFFFF;
          4:       cfg_word = 16'd2047;
          5:       cfg_word = 16'($urandom_range(16'hFFFF));
          default: cfg_word = 16'($urandom_range(2, 12));
        endcase
        // Grow the width mid-frame only over columns already stored.
        if (row_pos == 0 || active_width(cfg_word[LW_W-1:0]) <= filled_prefix())
          write_reg(REG_LINE_WIDTH, cfg_word);
      end
      if ($urandom_range(9) >= 4) begin
        case ($urandom_range(7))
          0:       cfg_word = 16'd0;
          1:       cfg_word = 16'd1;
          2:       cfg_word = 16'hFFFF;
          3:       cfg_word = 16'($urandom_range(16'hFFFF));
          default: cfg_word = 16'($urandom_range(1, 6));
        endcase
        write_reg(REG_FRAME_ROWS, cfg_word);
      end
      burst = pixels_to_frame_end();
      if ($urandom_range(3) == 0 || burst > 300) burst = $urandom_range(1, 40);
      repeat (burst) push_pixel(rand_pixel(), 1'b0, NO_BEAT);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("gradient_magnitude_stream_unit regression: pass");
    end else begin
      $display("gradient_magnitude_stream_unit regression: fail");
    end
    $finish;
  end

endmodule
